// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/jsu_pkg.sv =====
package jsu_pkg;

   // default number of queued result groups between front and back
   localparam int QUEUE_DEPTH = 4;

   // decoder mode
   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_STR  = 2'd1,
      MODE_ESC  = 2'd2,
      MODE_HEX  = 2'd3
   } mode_type;

   // error codes on the result channel
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_NO_QUOTE = 2'd1;
   localparam logic [1:0] ERR_BAD_ESC  = 2'd2;
   localparam logic [1:0] ERR_BAD_HEX  = 2'd3;

   // characters of interest
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_BS = 8'h08;
   localparam logic [7:0] CH_FF = 8'h0C;
   localparam logic [7:0] CH_LO_B = 8'h62;
   localparam logic [7:0] CH_LO_F = 8'h66;
   localparam logic [7:0] CH_LO_N = 8'h6E;
   localparam logic [7:0] CH_LO_R = 8'h72;
   localparam logic [7:0] CH_LO_T = 8'h74;
   localparam logic [7:0] CH_LO_U = 8'h75;

   // utf-8 encoding constants
   localparam logic [15:0] UTF8_MAX1 = 16'h007F;
   localparam logic [15:0] UTF8_MAX2 = 16'h07FF;
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_CONT = 8'h80;
   localparam logic [5:0] UTF8_MASK = 6'h3F;

   // results caused by one request
   typedef struct packed {
      logic [1:0] cnt;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic       string_end;
      logic [1:0] error_code;
   } task_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== hdl/jsu_front.sv =====
`include "assert_macros.svh"

module jsu_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   input  jsu_pkg::q_status_type q_status,
   output logic               push,
   output jsu_pkg::task_type  push_task
);

   jsu_pkg::mode_type mode_ff, mode_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_accum_ff, code_accum_in;

   logic        accept;
   logic        is_ws;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic        esc_ok;
   logic [7:0]  esc_byte;
   logic [15:0] code;
   jsu_pkg::task_type tsk;

   assign req_ready = !q_status.full;
   assign accept = req_valid && req_ready;

   // whitespace skipped while idle
   assign is_ws = (req_in_byte inside {jsu_pkg::CH_SPACE, jsu_pkg::CH_LF,
                                       jsu_pkg::CH_CR, jsu_pkg::CH_TAB});

   // hex digit, either case
   always_comb begin
      hex_ok = 1'b1;
      hex_val = 4'd0;
      if (req_in_byte inside {[8'h30:8'h39]}) begin
         hex_val = req_in_byte[3:0];
      end else if (req_in_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         hex_val = 4'(req_in_byte[2:0] + 3'd1) + 4'd8;
      end else begin
         hex_ok = 1'b0;
      end
   end

   // single-byte escape letters
   always_comb begin
      esc_ok = 1'b1;
      esc_byte = 8'd0;
      case (req_in_byte)
         jsu_pkg::CH_QUOTE:  esc_byte = jsu_pkg::CH_QUOTE;
         jsu_pkg::CH_BSLASH: esc_byte = jsu_pkg::CH_BSLASH;
         jsu_pkg::CH_SLASH:  esc_byte = jsu_pkg::CH_SLASH;
         jsu_pkg::CH_LO_B:   esc_byte = jsu_pkg::CH_BS;
         jsu_pkg::CH_LO_F:   esc_byte = jsu_pkg::CH_FF;
         jsu_pkg::CH_LO_N:   esc_byte = jsu_pkg::CH_LF;
         jsu_pkg::CH_LO_R:   esc_byte = jsu_pkg::CH_CR;
         jsu_pkg::CH_LO_T:   esc_byte = jsu_pkg::CH_TAB;
         default:            esc_ok = 1'b0;
      endcase
   end

   assign code = {code_accum_ff[11:0], hex_val};

   // next state
   always_comb begin
      mode_in = mode_ff;
      hex_count_in = hex_count_ff;
      code_accum_in = code_accum_ff;
      if (accept) begin
         case (mode_ff)
            jsu_pkg::MODE_IDLE: begin
               if (req_in_byte == jsu_pkg::CH_QUOTE) mode_in = jsu_pkg::MODE_STR;
            end
            jsu_pkg::MODE_STR: begin
               if (req_in_byte == jsu_pkg::CH_QUOTE) begin
                  mode_in = jsu_pkg::MODE_IDLE;
               end else if (req_in_byte == jsu_pkg::CH_BSLASH) begin
                  mode_in = jsu_pkg::MODE_ESC;
               end
            end
            jsu_pkg::MODE_ESC: begin
               if (req_in_byte == jsu_pkg::CH_LO_U) begin
                  mode_in = jsu_pkg::MODE_HEX;
                  hex_count_in = 2'd0;
                  code_accum_in = 16'd0;
               end else if (esc_ok) begin
                  mode_in = jsu_pkg::MODE_STR;
               end else begin
                  mode_in = jsu_pkg::MODE_IDLE;
               end
            end
            jsu_pkg::MODE_HEX: begin
               if (!hex_ok) begin
                  mode_in = jsu_pkg::MODE_IDLE;
                  hex_count_in = 2'd0;
                  code_accum_in = 16'd0;
               end else if (hex_count_ff == 2'd3) begin
                  mode_in = jsu_pkg::MODE_STR;
                  hex_count_in = 2'd0;
                  code_accum_in = 16'd0;
               end else begin
                  hex_count_in = hex_count_ff + 2'd1;
                  code_accum_in = code;
               end
            end
            default: mode_in = jsu_pkg::MODE_IDLE;
         endcase
      end
   end

   // results for this request
   always_comb begin
      tsk = '0;
      case (mode_ff)
         jsu_pkg::MODE_IDLE: begin
            if (!is_ws && req_in_byte != jsu_pkg::CH_QUOTE) begin
               tsk.cnt = 2'd1;
               tsk.error_code = jsu_pkg::ERR_NO_QUOTE;
            end
         end
         jsu_pkg::MODE_STR: begin
            if (req_in_byte == jsu_pkg::CH_QUOTE) begin
               tsk.cnt = 2'd1;
               tsk.string_end = 1'b1;
            end else if (req_in_byte != jsu_pkg::CH_BSLASH) begin
               tsk.cnt = 2'd1;
               tsk.b0 = req_in_byte;
            end
         end
         jsu_pkg::MODE_ESC: begin
            if (esc_ok) begin
               tsk.cnt = 2'd1;
               tsk.b0 = esc_byte;
            end else if (req_in_byte != jsu_pkg::CH_LO_U) begin
               tsk.cnt = 2'd1;
               tsk.error_code = jsu_pkg::ERR_BAD_ESC;
            end
         end
         jsu_pkg::MODE_HEX: begin
            if (!hex_ok) begin
               tsk.cnt = 2'd1;
               tsk.error_code = jsu_pkg::ERR_BAD_HEX;
            end else if (hex_count_ff == 2'd3) begin
               if (code <= jsu_pkg::UTF8_MAX1) begin
                  tsk.cnt = 2'd1;
                  tsk.b0 = code[7:0];
               end else if (code <= jsu_pkg::UTF8_MAX2) begin
                  tsk.cnt = 2'd2;
                  tsk.b0 = jsu_pkg::UTF8_LEAD2 | {3'd0, code[10:6]};
                  tsk.b1 = jsu_pkg::UTF8_CONT | {2'd0, code[5:0] & jsu_pkg::UTF8_MASK};
               end else begin
                  tsk.cnt = 2'd3;
                  tsk.b0 = jsu_pkg::UTF8_LEAD3 | {4'd0, code[15:12]};
                  tsk.b1 = jsu_pkg::UTF8_CONT | {2'd0, code[11:6] & jsu_pkg::UTF8_MASK};
                  tsk.b2 = jsu_pkg::UTF8_CONT | {2'd0, code[5:0] & jsu_pkg::UTF8_MASK};
               end
            end
         end
         default: tsk = '0;
      endcase
   end

   assign push = accept && (tsk.cnt != 2'd0);
   assign push_task = tsk;

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= jsu_pkg::MODE_IDLE;
         hex_count_ff <= 2'd0;
         code_accum_ff <= 16'd0;
      end else begin
         mode_ff <= mode_in;
         hex_count_ff <= hex_count_in;
         code_accum_ff <= code_accum_in;
      end
   end

   `ASSERT_IMPL(a_hex_count_mode, clock, reset, hex_count_ff != 2'd0, mode_ff == jsu_pkg::MODE_HEX, "hex digits counted outside a unicode escape")
   `ASSERT_NEXT(a_esc_leaves, clock, reset, accept && mode_ff == jsu_pkg::MODE_ESC, mode_ff != jsu_pkg::MODE_ESC, "escape mode held past its letter")

endmodule

// ===== hdl/jsu_queue.sv =====
`include "assert_macros.svh"

module jsu_queue #(
   parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  jsu_pkg::task_type    push_task,
   input  logic                 pop,
   output jsu_pkg::task_type    head,
   output jsu_pkg::q_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   jsu_pkg::task_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // pointer and fill count
   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop) rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ff] <= push_task;
   end

   assign head = slots_ff[rd_ff];
   assign q_status.full = (cnt_ff == CNT_W'(DEPTH));
   assign q_status.empty = (cnt_ff == '0);

   `ASSERT_IMPL(a_no_overflow, clock, reset, push, !q_status.full, "request pushed into a full queue")
   `ASSERT_IMPL(a_no_underflow, clock, reset, pop, !q_status.empty, "pop from an empty queue")

endmodule

// ===== hdl/jsu_back.sv =====
`include "assert_macros.svh"

module jsu_back (
   input  logic                 clock,
   input  logic                 reset,
   input  jsu_pkg::task_type    head,
   input  jsu_pkg::q_status_type q_status,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_string_end,
   output logic [1:0]           rsp_error_code,
   output logic                 rsp_last
);

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff;
   logic       end_ff;
   logic [1:0] err_ff;
   logic       last_ff;

   logic       load;
   logic       fire;
   logic       is_last;
   logic [7:0] sel_byte;

   // output register free, head group available
   assign load = !rsp_valid_ff || rsp_ready;
   assign fire = load && !q_status.empty;
   assign is_last = (idx_ff == head.cnt - 2'd1);
   assign pop = fire && is_last;

   // byte of the head group at the current position
   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = head.b0;
         2'd1:    sel_byte = head.b1;
         2'd2:    sel_byte = head.b2;
         default: sel_byte = 8'd0;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (fire) idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      rsp_valid_in = load ? !q_status.empty : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff <= sel_byte;
         end_ff <= head.string_end;
         err_ff <= head.error_code;
         last_ff <= is_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_string_end = end_ff;
   assign rsp_error_code = err_ff;
   assign rsp_last = last_ff;

   `ASSERT_IMPL(a_idx_needs_head, clock, reset, idx_ff != 2'd0, !q_status.empty, "group position set with nothing queued")
   `ASSERT_IMPL(a_err_zero_byte, clock, reset, rsp_valid_ff && err_ff != jsu_pkg::ERR_NONE, byte_ff == 8'd0 && !end_ff && last_ff, "error result carries data")

endmodule

// ===== hdl/json_string_unescape.sv =====
// decoded results are queued, then loaded into the output register on rsp_
// throughput: one request per cycle while the queue is not full; results go out
// one at a time, so a unicode escape giving three bytes yields three results
// a queue of QUEUE_DEPTH result groups lets the decoder run ahead of the output
// reset: synchronous, active high; decoder back to idle, queue and output emptied
module json_string_unescape #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_string_end,
   output logic [1:0] rsp_error_code,
   output logic       rsp_last
);

   logic                  push;
   logic                  pop;
   jsu_pkg::task_type     push_task;
   jsu_pkg::task_type     head;
   jsu_pkg::q_status_type q_status;

   // classify and decode incoming bytes
   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .q_status    (q_status),
      .push        (push),
      .push_task   (push_task)
   );

   // pending result groups
   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_task (push_task),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   // send results one per cycle unless rsp_ready stalls them
   jsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_string_end (rsp_string_end),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

endmodule
